// ===== src/swrl_pkg.sv =====
// Package: shared types and codes for the sliding-window rate limiter.
package swrl_pkg;

	// Table geometry; both are powers of two so ring positions wrap on their bits.
	localparam int KEY_COUNT    = 16;
	localparam int WINDOW_DEPTH = 16;

	typedef enum logic [1:0] {
		REQ_ADMIT  = 2'd0,
		REQ_REPORT = 2'd1,
		REQ_QUERY  = 2'd2,
		REQ_SPARE  = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		ST_ADMITTED = 3'd0,
		ST_BLOCKED  = 3'd1,
		ST_BURST    = 3'd2,
		ST_OVER     = 3'd3,
		ST_REPORTED = 3'd4,
		ST_COUNT    = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		CFG_MAX_REQ   = 3'd0,
		CFG_LOOP_THR  = 3'd1,
		CFG_BLOCK_MS  = 3'd2,
		CFG_WINDOW_MS = 3'd3,
		CFG_BURST_MS  = 3'd4
	} cfg_index_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_READ,
		BK_POP,
		BK_DECIDE,
		BK_NEWEST,
		BK_JUDGE,
		BK_OUT
	} bk_state_t;

	// Decoded command handed from front to back.
	typedef struct packed {
		req_type_t   kind;
		logic [7:0]  key;
		logic [31:0] now;
	} cmd_t;

	typedef struct packed {
		logic [4:0]  max_requests;
		logic [4:0]  loop_threshold;
		logic [15:0] block_ms;
		logic [15:0] window_ms;
		logic [15:0] burst_ms;
	} cfg_t;

endpackage

// ===== src/swrl_if.sv =====
// Interfaces: request, result and configuration channels.
interface swrl_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [3:0]  key_id;
	logic [31:0] now_ms;
	modport source (output valid, req_type, key_id, now_ms, input ready);
	modport sink   (input valid, req_type, key_id, now_ms, output ready);
endinterface

interface swrl_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [4:0] in_window;
	modport source (output valid, status, in_window, input ready);
	modport sink   (input valid, status, in_window, output ready);
endinterface

interface swrl_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/swrl_front.sv =====
// Front end: accepts request words and queues decoded commands.
module swrl_front (
	input  logic            clk,
	input  logic            arst_n,
	swrl_req_if.sink        req,
	output swrl_pkg::cmd_t  cmd,
	output logic            cmd_valid,
	input  logic            cmd_ready
);
	// Two-entry queue.
	swrl_pkg::cmd_t q_q [2];
	logic [1:0] cnt_q;
	logic       rd_q, wr_q;
	logic       push, pop;
	swrl_pkg::cmd_t in_cmd;

	// Sixteen keys: a 4-bit key index needs no folding.
	always_comb begin
		in_cmd      = '0;
		in_cmd.kind = swrl_pkg::req_type_t'(req.req_type);
		in_cmd.key  = 8'(req.key_id);
		in_cmd.now  = req.now_ms;
	end

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = q_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_q[wr_q] <= in_cmd;
	end
endmodule

// ===== src/swrl_back.sv =====
// Back end: per-key ring of stamps, stale-stamp removal, block and limit decisions.
module swrl_back (
	input  logic            clk,
	input  logic            arst_n,
	input  swrl_pkg::cmd_t  cmd,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  swrl_pkg::cfg_t  cfg,
	output logic            busy,
	swrl_rsp_if.source      rsp
);
	localparam int KEY_COUNT    = swrl_pkg::KEY_COUNT;
	localparam int WINDOW_DEPTH = swrl_pkg::WINDOW_DEPTH;
	localparam int KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
	localparam int DW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int FW = $clog2(WINDOW_DEPTH + 1);
	localparam int AW = KW + DW;

	logic [31:0] mem_q [KEY_COUNT*WINDOW_DEPTH];
	logic [DW-1:0] head_q [KEY_COUNT];
	logic [FW-1:0] fill_q [KEY_COUNT];
	logic [KEY_COUNT-1:0] blk_q;
	logic [31:0] bstart_q [KEY_COUNT];

	swrl_pkg::bk_state_t st_q, st_d;
	swrl_pkg::cmd_t c_q;
	logic [KW-1:0] k;
	logic [31:0]   rdata_q;
	logic [DW-1:0] rpos;
	logic          rd_en;
	logic [2:0]    status_q;
	logic [4:0]    cnt_out_q;
	logic          ov_q;
	logic          take;
	logic          burst_hit;

	logic [DW-1:0] h;
	logic [FW-1:0] f;
	logic [31:0]   age, bage;

	assign k    = c_q.key[KW-1:0];
	assign h    = head_q[k];
	assign f    = fill_q[k];
	assign age  = c_q.now - rdata_q;
	assign bage = c_q.now - bstart_q[k];

	// Burst: a zero loop threshold always trips; otherwise the newest stamp must
	// be young and the stored count at or above the threshold.
	assign burst_hit = (cfg.loop_threshold == 5'd0)
		|| (f != '0 && age < 32'(cfg.burst_ms) && 5'(f) >= cfg.loop_threshold);

	// Next command starts only once the previous result is gone or leaving.
	assign cmd_ready = (st_q == swrl_pkg::BK_IDLE) && (!ov_q || rsp.ready);
	assign take      = cmd_valid && cmd_ready;
	assign busy      = (st_q != swrl_pkg::BK_IDLE);
	assign rsp.valid = ov_q;
	assign rsp.status    = status_q;
	assign rsp.in_window = cnt_out_q;

	// Read position: oldest for removal, newest for the burst check.
	always_comb begin
		rpos  = h;
		rd_en = 1'b0;
		case (st_q)
			swrl_pkg::BK_READ: rd_en = 1'b1;
			swrl_pkg::BK_DECIDE: begin
				rpos  = DW'(32'(h) + 32'(f) - 32'd1);
				rd_en = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) rdata_q <= mem_q[{k, rpos}];
		if (st_q == swrl_pkg::BK_JUDGE && !burst_hit && 5'(f) < cfg.max_requests
			&& 32'(f) < WINDOW_DEPTH)
			mem_q[AW'({k, DW'(32'(h) + 32'(f))})] <= c_q.now;
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			swrl_pkg::BK_IDLE:
				if (take)
					st_d = (cmd.kind == swrl_pkg::REQ_ADMIT) ? swrl_pkg::BK_READ
						: swrl_pkg::BK_OUT;
			swrl_pkg::BK_READ:
				st_d = (f == '0) ? swrl_pkg::BK_DECIDE : swrl_pkg::BK_POP;
			swrl_pkg::BK_POP:
				st_d = (age > 32'(cfg.window_ms)) ? swrl_pkg::BK_READ
					: swrl_pkg::BK_DECIDE;
			swrl_pkg::BK_DECIDE:
				st_d = (blk_q[k] && bage < 32'(cfg.block_ms)) ? swrl_pkg::BK_OUT
					: swrl_pkg::BK_NEWEST;
			swrl_pkg::BK_NEWEST: st_d = swrl_pkg::BK_JUDGE;
			swrl_pkg::BK_JUDGE:  st_d = swrl_pkg::BK_OUT;
			swrl_pkg::BK_OUT:    if (!ov_q) st_d = swrl_pkg::BK_IDLE;
			default: st_d = swrl_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= swrl_pkg::BK_IDLE;
			ov_q <= 1'b0;
			blk_q <= '0;
			for (int i = 0; i < KEY_COUNT; i++) begin
				head_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else begin
			st_q <= st_d;
			if (rsp.valid && rsp.ready) ov_q <= 1'b0;
			case (st_q)
				swrl_pkg::BK_IDLE:
					if (take) begin
						if (cmd.kind == swrl_pkg::REQ_REPORT)
							blk_q[cmd.key[KW-1:0]] <= 1'b1;
					end
				swrl_pkg::BK_POP:
					if (age > 32'(cfg.window_ms)) begin
						head_q[k] <= DW'(32'(h) + 32'd1);
						fill_q[k] <= f - FW'(1);
					end
				swrl_pkg::BK_DECIDE:
					if (blk_q[k] && !(bage < 32'(cfg.block_ms))) blk_q[k] <= 1'b0;
				swrl_pkg::BK_JUDGE:
					if (burst_hit) blk_q[k] <= 1'b1;
					else if (5'(f) < cfg.max_requests && 32'(f) < WINDOW_DEPTH)
						fill_q[k] <= f + FW'(1);
					else blk_q[k] <= 1'b1;
				swrl_pkg::BK_OUT:
					if (!ov_q) ov_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		case (st_q)
			swrl_pkg::BK_IDLE:
				if (take) begin
					c_q <= cmd;
					status_q <= (cmd.kind == swrl_pkg::REQ_REPORT) ? swrl_pkg::ST_REPORTED
						: swrl_pkg::ST_COUNT;
					if (cmd.kind == swrl_pkg::REQ_REPORT) bstart_q[cmd.key[KW-1:0]] <= cmd.now;
				end
			swrl_pkg::BK_DECIDE:
				status_q <= swrl_pkg::ST_BLOCKED;
			swrl_pkg::BK_JUDGE:
				if (burst_hit) begin
					status_q <= swrl_pkg::ST_BURST;
					bstart_q[k] <= c_q.now;
				end else if (5'(f) < cfg.max_requests && 32'(f) < WINDOW_DEPTH)
					status_q <= swrl_pkg::ST_ADMITTED;
				else begin
					status_q <= swrl_pkg::ST_OVER;
					bstart_q[k] <= c_q.now;
				end
			swrl_pkg::BK_OUT:
				if (!ov_q) cnt_out_q <= 5'(fill_q[k]);
			default: ;
		endcase
	end
endmodule

// ===== src/sliding_window_rate_limiter.sv =====
// Top level: per-key sliding-window rate limiter.
//
// Channels: req (sink) carries req_type, key_id, now_ms; rsp (source) returns
// status and in_window, one word per request; cfg (sink) writes the five
// registers by index (0 max_requests .. 4 burst_ms), taken only while idle.
// A front stage takes request words into a two-entry queue; the back stage
// walks the key's stamp ring in one memory, removing stale stamps one at a
// time through its read and pop states, at most WINDOW_DEPTH per admit word;
// the single read port of the stamp memory sets this pace. Report and query
// words skip the ring, and an admit word for a key that is still blocked
// skips the burst and limit checks. One item is in the back at a time; the
// queue lets the next words land meanwhile.
// Reset clears ring heads, fills and block flags and loads register defaults
// (10, 5, 5000, 1000, 100); the stamp memory needs no clearing.
// When rsp is stalled the result holds in its output register and the back
// stage waits idle until it is taken; the front keeps accepting until its
// queue is full.
module sliding_window_rate_limiter (
	input logic        clk,
	input logic        arst_n,
	swrl_req_if.sink   req,
	swrl_rsp_if.source rsp,
	swrl_cfg_if.sink   cfg
);
	swrl_pkg::cmd_t cmd;
	logic           cmd_valid, cmd_ready, busy;
	swrl_pkg::cfg_t cfg_q;

	// Registers change only with no command in the back or waiting for it.
	assign cfg.ready = !busy && !cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_requests   <= 5'd10;
			cfg_q.loop_threshold <= 5'd5;
			cfg_q.block_ms       <= 16'd5000;
			cfg_q.window_ms      <= 16'd1000;
			cfg_q.burst_ms       <= 16'd100;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				swrl_pkg::CFG_MAX_REQ:   cfg_q.max_requests   <= cfg.data[4:0];
				swrl_pkg::CFG_LOOP_THR:  cfg_q.loop_threshold <= cfg.data[4:0];
				swrl_pkg::CFG_BLOCK_MS:  cfg_q.block_ms       <= cfg.data;
				swrl_pkg::CFG_WINDOW_MS: cfg_q.window_ms      <= cfg.data;
				swrl_pkg::CFG_BURST_MS:  cfg_q.burst_ms       <= cfg.data;
				default: ;
			endcase
		end
	end

	swrl_front u_front (
		.clk, .arst_n, .req, .cmd, .cmd_valid, .cmd_ready
	);

	swrl_back u_back (
		.clk, .arst_n, .cmd, .cmd_valid, .cmd_ready, .cfg(cfg_q), .busy, .rsp
	);

	// A result word never changes while it waits.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status)
			&& $stable(rsp.in_window)) else $error("result changed under stall");

	// Back stage takes a command only when idle.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> busy) else $error("command lost");

	// Stored count never exceeds the ring depth.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> 32'(rsp.in_window) <= swrl_pkg::WINDOW_DEPTH)
		else $error("count overflow");
endmodule
